FILE: rtl/hdi_pkg.sv
// ----------------------------------------------------------------------------
// hdi_pkg
// shared types, code tables and bch helper for the hdmi data island encoder
// ----------------------------------------------------------------------------
package hdi_pkg;

  localparam int unsigned PacketWords     = 32;
  localparam int unsigned DefPreamblePix  = 8;
  localparam int unsigned SubpacketBytes  = 7;
  localparam int unsigned HeaderBytes     = 3;
  localparam int unsigned NumSubpackets   = 4;

  localparam logic [9:0] Ctl00    = 10'h354;
  localparam logic [9:0] Ctl01    = 10'h0AB;
  localparam logic [9:0] Ctl10    = 10'h154;
  localparam logic [9:0] Ctl11    = 10'h2AB;
  localparam logic [9:0] GbCode   = 10'h133;
  localparam logic [7:0] BchMask  = 8'h83;
  localparam logic [1:0] GbPrefix = 2'b11;

  // packet handed from the bch lanes to the word sequencer
  typedef struct packed {
    logic [31:0]                  header;
    logic [NumSubpackets-1:0][63:0] sp;
    logic                         first;
    logic                         last;
    logic [1:0]                   hv;
    logic                         pre_en;
  } pkt_t;

  // one byte of the bch shift register, lsb first
  function automatic logic [7:0] bch_step(input logic [7:0] ecc, input logic [7:0] din);
    logic [7:0] e;
    logic       fb;
    e = ecc;
    for (int i = 0; i < 8; i++) begin
      fb = e[0] ^ din[i];
      e  = {1'b0, e[7:1]} ^ (fb ? BchMask : 8'h00);
    end
    return e;
  endfunction

  function automatic logic [9:0] terc4(input logic [3:0] d);
    logic [9:0] c;
    case (d)
      4'h0:    c = 10'h29C;
      4'h1:    c = 10'h263;
      4'h2:    c = 10'h2E4;
      4'h3:    c = 10'h2E2;
      4'h4:    c = 10'h171;
      4'h5:    c = 10'h11E;
      4'h6:    c = 10'h18E;
      4'h7:    c = 10'h13C;
      4'h8:    c = 10'h2CC;
      4'h9:    c = 10'h139;
      4'hA:    c = 10'h19C;
      4'hB:    c = 10'h2C6;
      4'hC:    c = 10'h28E;
      4'hD:    c = 10'h271;
      4'hE:    c = 10'h163;
      4'hF:    c = 10'h2C3;
      default: c = 10'h29C;
    endcase
    return c;
  endfunction

  function automatic logic [9:0] ctl_code(input logic [1:0] d);
    logic [9:0] c;
    case (d)
      2'd0:    c = Ctl00;
      2'd1:    c = Ctl01;
      2'd2:    c = Ctl10;
      2'd3:    c = Ctl11;
      default: c = Ctl00;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/hdi_bch_lane.sv
// ----------------------------------------------------------------------------
// hdi_bch_lane
// bch ecc byte over one header or subpacket, one data byte per cycle
// ----------------------------------------------------------------------------
module hdi_bch_lane import hdi_pkg::*; #(
  parameter int unsigned NBYTES = SubpacketBytes
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  logic [NBYTES*8-1:0]   data_i,
  output logic [7:0]            ecc_o,
  output logic                  done_o
);

  localparam int unsigned CW = $clog2(NBYTES + 1);

  logic [CW-1:0]       cnt_q;
  logic [7:0]          ecc_q;
  logic [NBYTES*8-1:0] sh_q;

  assign done_o = (cnt_q == CW'(NBYTES));
  assign ecc_o  = ecc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CW'(NBYTES);
    end else if (load_i) begin
      cnt_q <= '0;
    end else if (!done_o) begin
      cnt_q <= cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ecc_q <= '0;
      sh_q  <= data_i;
    end else if (!done_o) begin
      ecc_q <= bch_step(ecc_q, sh_q[7:0]);
      sh_q  <= sh_q >> 8;
    end
  end

endmodule

FILE: rtl/hdi_word_seq.sv
// ----------------------------------------------------------------------------
// hdi_word_seq
// merges lane results into the tmds word stream of one packet
// ----------------------------------------------------------------------------
module hdi_word_seq import hdi_pkg::*; #(
  parameter int unsigned PREAMBLE_PIXELS = DefPreamblePix
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_valid_i,
  output logic        load_ready_o,
  input  pkt_t        load_pkt_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [29:0] tmds_word_o,
  output logic        last_word_o
);

  localparam int unsigned CNT_W = (PREAMBLE_PIXELS > PacketWords) ?
                                  $clog2(PREAMBLE_PIXELS) : $clog2(PacketWords);

  localparam logic [1:0] PH_PRE  = 2'd0;
  localparam logic [1:0] PH_GBL  = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;
  localparam logic [1:0] PH_GBT  = 2'd3;

  logic [1:0]       ph_q, ph_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             active_q;
  logic             out_valid_q;
  logic [29:0]      tmds_q;
  logic             last_q;

  logic [31:0]                    hdr_q;
  logic [NumSubpackets-1:0][63:0] sp_q;
  logic                           first_q;
  logic                           last_pkt_q;
  logic [1:0]                     hv_q;

  logic        adv;
  logic        load;
  logic        word_last;
  logic [29:0] word;
  logic [3:0]  c0, c1, c2;

  assign adv          = active_q && (!out_valid_q || out_ready_i);
  assign load_ready_o = !active_q || (adv && word_last);
  assign load         = load_valid_i && load_ready_o;

  always_comb begin
    for (int s = 0; s < NumSubpackets; s++) begin
      c1[s] = sp_q[s][0];
      c2[s] = sp_q[s][1];
    end
    // start flag is cleared on the first data word of an island
    c0 = {!(first_q && cnt_q == '0), hdr_q[0], hv_q};
  end

  always_comb begin
    word      = '0;
    word_last = 1'b0;
    ph_d      = ph_q;
    cnt_d     = cnt_q + CNT_W'(1);
    case (ph_q)
      PH_PRE: begin
        word = {Ctl01, Ctl01, ctl_code(hv_q)};
        if (cnt_q == CNT_W'(PREAMBLE_PIXELS - 1)) begin
          ph_d  = PH_GBL;
          cnt_d = '0;
        end
      end
      PH_GBL: begin
        word = {GbCode, GbCode, terc4({GbPrefix, hv_q})};
        if (cnt_q == CNT_W'(1)) begin
          ph_d  = PH_DATA;
          cnt_d = '0;
        end
      end
      PH_DATA: begin
        word = {terc4(c2), terc4(c1), terc4(c0)};
        if (cnt_q == CNT_W'(PacketWords - 1)) begin
          ph_d      = PH_GBT;
          cnt_d     = '0;
          word_last = !last_pkt_q;
        end
      end
      PH_GBT: begin
        word      = {GbCode, GbCode, terc4({GbPrefix, hv_q})};
        word_last = (cnt_q == CNT_W'(1));
      end
      default: begin
        word = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
      ph_q        <= PH_DATA;
      cnt_q       <= '0;
    end else begin
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (load) begin
        active_q <= 1'b1;
        cnt_q    <= '0;
        if (load_pkt_i.first && load_pkt_i.pre_en) begin
          ph_q <= PH_PRE;
        end else if (load_pkt_i.first) begin
          ph_q <= PH_GBL;
        end else begin
          ph_q <= PH_DATA;
        end
      end else if (adv) begin
        ph_q  <= ph_d;
        cnt_q <= cnt_d;
        if (word_last) begin
          active_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tmds_q <= word;
      last_q <= word_last;
    end
    if (load) begin
      hdr_q      <= load_pkt_i.header;
      sp_q       <= load_pkt_i.sp;
      first_q    <= load_pkt_i.first;
      last_pkt_q <= load_pkt_i.last;
      hv_q       <= load_pkt_i.hv;
    end else if (adv && ph_q == PH_DATA) begin
      hdr_q <= hdr_q >> 1;
      for (int s = 0; s < NumSubpackets; s++) begin
        sp_q[s] <= sp_q[s] >> 2;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign tmds_word_o = tmds_q;
  assign last_word_o = last_q;

endmodule

FILE: rtl/hdmi_data_island_encoder.sv
// ----------------------------------------------------------------------------
// hdmi_data_island_encoder
// flow: a taken packet goes through the bch lanes into the word sequencer
// throughput: one tmds word per cycle while out_ready_i is high, 32 to 44
//   words per packet; the word sequencer sets the packet rate, lanes overlap it
// reset: rst_ni async active low, preamble_enable resets to 1, no words pending
// ----------------------------------------------------------------------------
module hdmi_data_island_encoder import hdi_pkg::*; #(
  parameter int unsigned PREAMBLE_PIXELS = DefPreamblePix
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_preamble_enable_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [23:0] packet_header_i,
  input  logic [55:0] subpacket_0_i,
  input  logic [55:0] subpacket_1_i,
  input  logic [55:0] subpacket_2_i,
  input  logic [55:0] subpacket_3_i,
  input  logic        first_in_island_i,
  input  logic        last_in_island_i,
  input  logic        hsync_active_i,
  input  logic        vsync_active_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [29:0] tmds_word_o,
  output logic        last_word_o
);

  logic pre_en_q;
  logic pend_q;
  logic accept;
  logic handoff;
  logic seq_ready;

  logic [23:0]                    hdr_q;
  logic [NumSubpackets-1:0][55:0] sp_q;
  logic                           first_q;
  logic                           last_q;
  logic [1:0]                     hv_q;

  logic [NumSubpackets-1:0][55:0] sp_in;
  logic [NumSubpackets-1:0][7:0]  sp_ecc;
  logic [NumSubpackets-1:0]       sp_done;
  logic [7:0]                     hdr_ecc;
  logic                           hdr_done;
  pkt_t                           pkt;

  assign cfg_ready_o = 1'b1;
  assign sp_in       = {subpacket_3_i, subpacket_2_i, subpacket_1_i, subpacket_0_i};

  assign handoff    = pend_q && hdr_done && (&sp_done) && seq_ready;
  assign in_ready_o = !pend_q || handoff;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_en_q <= 1'b1;
      pend_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        pre_en_q <= cfg_preamble_enable_i;
      end
      if (accept) begin
        pend_q <= 1'b1;
      end else if (handoff) begin
        pend_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hdr_q   <= packet_header_i;
      sp_q    <= sp_in;
      first_q <= first_in_island_i;
      last_q  <= last_in_island_i;
      // encoded line levels are the inverse of the active flags
      hv_q    <= {!vsync_active_i, !hsync_active_i};
    end
  end

  hdi_bch_lane #(
    .NBYTES (HeaderBytes)
  ) u_hdr_lane (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (accept),
    .data_i (packet_header_i),
    .ecc_o  (hdr_ecc),
    .done_o (hdr_done)
  );

  for (genvar s = 0; s < NumSubpackets; s++) begin : g_sp_lane
    hdi_bch_lane #(
      .NBYTES (SubpacketBytes)
    ) u_sp_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .load_i (accept),
      .data_i (sp_in[s]),
      .ecc_o  (sp_ecc[s]),
      .done_o (sp_done[s])
    );
  end

  always_comb begin
    pkt.header = {hdr_ecc, hdr_q};
    for (int s = 0; s < NumSubpackets; s++) begin
      pkt.sp[s] = {sp_ecc[s], sp_q[s]};
    end
    pkt.first  = first_q;
    pkt.last   = last_q;
    pkt.hv     = hv_q;
    pkt.pre_en = pre_en_q;
  end

  hdi_word_seq #(
    .PREAMBLE_PIXELS (PREAMBLE_PIXELS)
  ) u_word_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (pend_q && hdr_done && (&sp_done)),
    .load_ready_o (seq_ready),
    .load_pkt_i   (pkt),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .tmds_word_o  (tmds_word_o),
    .last_word_o  (last_word_o)
  );

endmodule
